/* design/password_lock_controller_unit_macros.svh */
// Assertion macros for the password lock controller.
// Included by the top level; no other dependencies.
`ifndef PASSWORD_LOCK_CONTROLLER_UNIT_MACROS_SVH
`define PASSWORD_LOCK_CONTROLLER_UNIT_MACROS_SVH

`ifndef SYNTHESIS
`define PLC_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("implication check failed");
`define PLC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("next-cycle check failed");
`else
`define PLC_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define PLC_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

/* design/plc_pkg.sv */
// Shared types, constants and helpers for the password lock controller.
// No dependencies; used by every module of the block.
package plc_pkg;

	localparam int PASSWORD_LEN = 5;
	localparam int IDX_W = (PASSWORD_LEN > 1) ? $clog2(PASSWORD_LEN) : 1;
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

	localparam logic ITEM_BYTE = 1'b0;
	localparam logic ITEM_TICK = 1'b1;

	localparam logic [1:0] MOTOR_STOP = 2'd0;
	localparam logic [1:0] MOTOR_CW = 2'd1;
	localparam logic [1:0] MOTOR_CCW = 2'd2;

	typedef enum logic [3:0] {
		PH_SETUP_A,
		PH_SETUP_B,
		PH_IDLE,
		PH_OPEN_PW,
		PH_CHG_OLD,
		PH_CHG_NEW_A,
		PH_CHG_NEW_B,
		PH_RUN_CW,
		PH_RUN_HOLD,
		PH_RUN_CCW,
		PH_ALARM
	} phase_t;

	typedef enum logic [2:0] {
		REG_MAX_FAILURES,
		REG_UNLOCK_TICKS,
		REG_HOLD_TICKS,
		REG_LOCK_TICKS,
		REG_ALARM_TICKS,
		REG_OPEN_CODE,
		REG_CHANGE_CODE
	} cfg_reg_t;

	typedef struct packed {
		logic       func;
		logic [7:0] data;
	} in_item_t;

	typedef struct packed {
		logic       has_reply;
		logic [7:0] reply;
		logic [1:0] motor_drive;
		logic       buzzer;
		logic       last;
	} out_item_t;

	typedef struct packed {
		logic [2:0] max_failures;
		logic [7:0] unlock_ticks;
		logic [7:0] hold_ticks;
		logic [7:0] lock_ticks;
		logic [7:0] alarm_ticks;
		logic [7:0] open_code;
		logic [7:0] change_code;
	} cfg_t;

	// One processed item: one or two result words.
	typedef struct packed {
		logic      two;
		out_item_t r0;
		out_item_t r1;
	} res_pair_t;

	typedef struct packed {
		phase_t phase;
		logic   busy;
	} core_stat_t;

	// Entering a timed phase with a zero duration falls through to the next one.
	function automatic phase_t enter_phase(phase_t p, cfg_t c);
		phase_t r;
		r = p;
		if (r == PH_RUN_CW && c.unlock_ticks == 8'd0) r = PH_RUN_HOLD;
		if (r == PH_RUN_HOLD && c.hold_ticks == 8'd0) r = PH_RUN_CCW;
		if (r == PH_RUN_CCW && c.lock_ticks == 8'd0) r = PH_IDLE;
		if (r == PH_ALARM && c.alarm_ticks == 8'd0) r = PH_IDLE;
		return r;
	endfunction

	function automatic logic is_timed(phase_t p);
		return (p == PH_RUN_CW) || (p == PH_RUN_HOLD) || (p == PH_RUN_CCW) || (p == PH_ALARM);
	endfunction

endpackage

/* design/plc_core.sv */
// Lock controller state: phases, password stores, failure and tick counters.
// Depends on plc_pkg. Produces one result pair per processed item.
module plc_core import plc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  in_item_t   item,
	input  cfg_t       cfg,
	output res_pair_t  res,
	output core_stat_t stat
);

	phase_t           phase_q, phase_d;
	logic [IDX_W-1:0] idx_q, idx_d;
	logic [2:0]       fail_q, fail_d;
	logic [7:0]       tick_q, tick_d;
	logic [7:0]       first_q [PASSWORD_LEN];
	logic [7:0]       second_q [PASSWORD_LEN];
	logic [7:0]       stored_q [PASSWORD_LEN];
	logic [7:0]       first_new [PASSWORD_LEN];
	logic [7:0]       second_new [PASSWORD_LEN];
	logic             full, match_stored, match_pair;
	logic             wr_first, wr_second, copy_stored;
	logic [2:0]       fail_inc;
	logic             alarm_hit;
	logic [7:0]       tick_inc, limit;
	phase_t           tick_next;
	logic             is_byte;

	assign is_byte = (item.func == ITEM_BYTE);
	assign full = (idx_q == IDX_W'(PASSWORD_LEN - 1));
	assign fail_inc = fail_q + 3'd1;
	assign alarm_hit = (fail_inc >= cfg.max_failures);
	assign tick_inc = tick_q + 8'd1;

	// Compare against the buffers as they will be once this byte is stored.
	always_comb begin
		match_stored = 1'b1;
		match_pair = 1'b1;
		for (int i = 0; i < PASSWORD_LEN; i++) begin
			first_new[i] = (idx_q == IDX_W'(i)) ? item.data : first_q[i];
			second_new[i] = (idx_q == IDX_W'(i)) ? item.data : second_q[i];
		end
		for (int i = 0; i < PASSWORD_LEN; i++) begin
			if (first_new[i] != stored_q[i]) match_stored = 1'b0;
			if (first_q[i] != second_new[i]) match_pair = 1'b0;
		end
	end

	always_comb begin
		limit = 8'd0;
		tick_next = PH_IDLE;
		case (phase_q)
			PH_RUN_CW: begin
				limit = cfg.unlock_ticks;
				tick_next = PH_RUN_HOLD;
			end
			PH_RUN_HOLD: begin
				limit = cfg.hold_ticks;
				tick_next = PH_RUN_CCW;
			end
			PH_RUN_CCW: begin
				limit = cfg.lock_ticks;
				tick_next = PH_IDLE;
			end
			PH_ALARM: begin
				limit = cfg.alarm_ticks;
				tick_next = PH_IDLE;
			end
			default: begin
				limit = 8'd0;
				tick_next = PH_IDLE;
			end
		endcase
	end

	// Next state.
	always_comb begin
		phase_d = phase_q;
		idx_d = idx_q;
		fail_d = fail_q;
		tick_d = tick_q;
		wr_first = 1'b0;
		wr_second = 1'b0;
		copy_stored = 1'b0;
		if (!is_byte) begin
			if (is_timed(phase_q)) begin
				if (tick_inc >= limit) begin
					phase_d = enter_phase(tick_next, cfg);
					tick_d = 8'd0;
				end else begin
					tick_d = tick_inc;
				end
			end
		end else begin
			case (phase_q)
				PH_SETUP_A, PH_CHG_NEW_A: begin
					wr_first = 1'b1;
					idx_d = full ? '0 : idx_q + 1'b1;
					if (full) phase_d = (phase_q == PH_SETUP_A) ? PH_SETUP_B : PH_CHG_NEW_B;
				end
				PH_SETUP_B, PH_CHG_NEW_B: begin
					wr_second = 1'b1;
					idx_d = full ? '0 : idx_q + 1'b1;
					if (full) begin
						copy_stored = match_pair;
						if (phase_q == PH_CHG_NEW_B || match_pair) phase_d = PH_IDLE;
						else phase_d = PH_SETUP_A;
					end
				end
				PH_IDLE: begin
					idx_d = '0;
					if (item.data == cfg.open_code) phase_d = PH_OPEN_PW;
					else if (item.data == cfg.change_code) phase_d = PH_CHG_OLD;
				end
				PH_OPEN_PW, PH_CHG_OLD: begin
					wr_first = 1'b1;
					idx_d = full ? '0 : idx_q + 1'b1;
					if (full) begin
						if (match_stored) begin
							fail_d = 3'd0;
							if (phase_q == PH_OPEN_PW) begin
								phase_d = enter_phase(PH_RUN_CW, cfg);
								tick_d = 8'd0;
							end else begin
								phase_d = PH_CHG_NEW_A;
							end
						end else begin
							tick_d = 8'd0;
							if (alarm_hit) begin
								fail_d = 3'd0;
								phase_d = enter_phase(PH_ALARM, cfg);
							end else begin
								fail_d = fail_inc;
								phase_d = PH_IDLE;
							end
						end
					end
				end
				default: begin
					phase_d = phase_q;
				end
			endcase
		end
	end

	// Result words; motor and buzzer show the state after this item.
	always_comb begin
		out_item_t base;
		base.has_reply = 1'b0;
		base.reply = 8'd0;
		base.motor_drive = (phase_d == PH_RUN_CW) ? MOTOR_CW :
			(phase_d == PH_RUN_CCW) ? MOTOR_CCW : MOTOR_STOP;
		base.buzzer = (phase_d == PH_ALARM);
		base.last = 1'b1;
		res.two = 1'b0;
		res.r0 = base;
		res.r1 = base;
		if (is_byte && full) begin
			case (phase_q)
				PH_SETUP_B, PH_CHG_NEW_B: begin
					res.r0.has_reply = 1'b1;
					res.r0.reply = {7'd0, match_pair};
				end
				PH_OPEN_PW, PH_CHG_OLD: begin
					res.r0.has_reply = 1'b1;
					res.r0.reply = {7'd0, match_stored};
					if (!match_stored) begin
						res.two = 1'b1;
						res.r0.last = 1'b0;
						res.r1.has_reply = 1'b1;
						res.r1.reply = {5'd0, fail_inc};
					end
				end
				default: begin
					res.two = 1'b0;
				end
			endcase
		end
	end

	assign stat.phase = phase_q;
	assign stat.busy = is_timed(phase_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SETUP_A;
			idx_q <= '0;
			fail_q <= 3'd0;
			tick_q <= 8'd0;
		end else if (step) begin
			phase_q <= phase_d;
			idx_q <= idx_d;
			fail_q <= fail_d;
			tick_q <= tick_d;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			if (wr_first) first_q[idx_q] <= item.data;
			if (wr_second) second_q[idx_q] <= item.data;
			if (copy_stored) begin
				for (int i = 0; i < PASSWORD_LEN; i++) begin
					stored_q[i] <= first_q[i];
				end
			end
		end
	end

endmodule

/* design/plc_result_fifo.sv */
// Result queue: takes one or two words per item, hands out one per ready cycle.
// Depends on plc_pkg.
module plc_result_fifo import plc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  res_pair_t res,
	output logic      room,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_item
);

	out_item_t             mem_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0] wr_q, rd_q;
	logic [FIFO_CNT_W-1:0] cnt_q;
	logic                  pop;
	logic [FIFO_CNT_W-1:0] n_push;

	assign out_valid = (cnt_q != '0);
	assign out_item = mem_q[rd_q];
	assign pop = out_valid && out_ready;
	// Room for the worst case of two words from one item.
	assign room = (cnt_q <= FIFO_CNT_W'(FIFO_DEPTH - 2));
	assign n_push = push ? (res.two ? FIFO_CNT_W'(2) : FIFO_CNT_W'(1)) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			wr_q <= wr_q + n_push[FIFO_PTR_W-1:0];
			if (pop) rd_q <= rd_q + 1'b1;
			cnt_q <= cnt_q + n_push - FIFO_CNT_W'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= res.r0;
			if (res.two) mem_q[wr_q + 1'b1] <= res.r1;
		end
	end

endmodule

/* design/password_lock_controller_unit.sv */
// Password lock controller: input register, state core and result queue.
// Depends on plc_pkg, plc_core, plc_result_fifo and the assertion macro header.
//
// Use: link bytes and one-second ticks enter on in_valid/in_ready as one word each
// (func 0 = byte, func 1 = tick). Every word yields one or two result words on
// out_valid/out_ready; a wrong password gives the match flag and then the failure
// count, the last word of each input carrying last = 1. The user must write
// registers on cfg_valid/cfg_ready (always ready) while the block is idle; unchecked.
// Path: an accepted word waits in the input register until the queue has room,
// then the core processes it and its results are written into the queue and offered.
// Throughput: one input word per cycle while the queue has room; a two-word result
// is handed out as two separate output words.
// A four-word result queue decouples the sides: the input stage accepts while
// results wait, and stalls only once the queue cannot take another two words.
// Reset: set-up phase waiting for the first password, counters cleared, all
// registers at their reset values; the password stores need no clearing.
module password_lock_controller_unit import plc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  in_item_t   in_item,
	output logic       out_valid,
	input  logic       out_ready,
	output out_item_t  out_item,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [2:0] cfg_index,
	input  logic [7:0] cfg_data
);

`include "password_lock_controller_unit_macros.svh"

	logic       valid_s1;
	in_item_t   item_s1;
	cfg_t       cfg_q;
	logic       room, step;
	res_pair_t  res;
	core_stat_t stat;

	assign cfg_ready = 1'b1;
	assign step = valid_s1 && room;
	assign in_ready = !valid_s1 || step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) item_s1 <= in_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_failures <= 3'd3;
			cfg_q.unlock_ticks <= 8'd15;
			cfg_q.hold_ticks <= 8'd3;
			cfg_q.lock_ticks <= 8'd15;
			cfg_q.alarm_ticks <= 8'd60;
			cfg_q.open_code <= 8'd43;
			cfg_q.change_code <= 8'd45;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_reg_t'(cfg_index))
				REG_MAX_FAILURES: cfg_q.max_failures <= cfg_data[2:0];
				REG_UNLOCK_TICKS: cfg_q.unlock_ticks <= cfg_data;
				REG_HOLD_TICKS: cfg_q.hold_ticks <= cfg_data;
				REG_LOCK_TICKS: cfg_q.lock_ticks <= cfg_data;
				REG_ALARM_TICKS: cfg_q.alarm_ticks <= cfg_data;
				REG_OPEN_CODE: cfg_q.open_code <= cfg_data;
				REG_CHANGE_CODE: cfg_q.change_code <= cfg_data;
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	plc_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.item   (item_s1),
		.cfg    (cfg_q),
		.res    (res),
		.stat   (stat)
	);

	plc_result_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (step),
		.res       (res),
		.room      (room),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

	// The motor and the buzzer never run together.
	`PLC_ASSERT_IMPLY(a_motor_buzzer_excl, clk, arst_n, out_valid && out_item.buzzer, out_item.motor_drive == MOTOR_STOP)
	// A word without a reply carries a zero reply byte.
	`PLC_ASSERT_IMPLY(a_no_reply_zero, clk, arst_n, out_valid && !out_item.has_reply, out_item.reply == 8'd0)
	// Bytes that arrive during a motor or buzzer run leave the phase alone.
	`PLC_ASSERT_NEXT(a_run_ignores_bytes, clk, arst_n, step && item_s1.func == ITEM_BYTE && stat.busy, stat.phase == $past(stat.phase))

endmodule
